>>> hdl/amgs_pkg.sv
// ----------------------------------------------------------------------------
// amgs_pkg
// Shared types and constants of the Gram-Schmidt Arnoldi step unit.
// ----------------------------------------------------------------------------
package amgs_pkg;

  localparam int MAX_ROWS    = 256;
  localparam int MAX_COLUMNS = 32;
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int COL_W       = 5;
  localparam int LEN_W       = 9;
  localparam int ADDR_W      = COL_W + ROW_W;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 40;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NOP   = 2'd3
  } amgs_mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BREAKDOWN = 2'd1,
    ST_RANGE     = 2'd2
  } amgs_status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_DOT, S_HOUT, S_UPD, S_NORM, S_SQRT,
    S_DRD, S_DLD, S_DIV, S_DWR, S_NOUT
  } amgs_state_t;

endpackage

>>> hdl/arnoldi_mgs_orthogonalize_unit.sv
// ----------------------------------------------------------------------------
// arnoldi_mgs_orthogonalize_unit
// Modified Gram-Schmidt step over a basis memory and a work vector memory.
// ----------------------------------------------------------------------------
// Loads and basis writes go straight into memory. A basis read passes through the
// memory read register and the S_READ state to the output register.
// A step's length is set by one memory read port per pass, 32 square root
// iterations and a 48-bit bit-serial divider per normalized row; output stalls
// add to it. One item in flight at a time.
// Reset: synchronous active low; clears control and sets vector_length to 256.
module arnoldi_mgs_orthogonalize_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [amgs_pkg::LEN_W-1:0]       cfg_wr_data,   // vector_length
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [amgs_pkg::IN_DATA_W-1:0]   in_tdata,      // column[4:0], row[12:5], value[44:13]
  input  logic [1:0]                       in_tuser,      // mode[1:0]
  input  logic                             in_tlast,      // last
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [amgs_pkg::OUT_DATA_W-1:0]  out_tdata,     // coeff_index[4:0], result_value[36:5]
  output logic [1:0]                       out_tuser,     // status[1:0]
  output logic                             out_tlast      // last_result
);
  import amgs_pkg::*;

  logic signed [31:0] bs_mem [MAX_ROWS*MAX_COLUMNS];
  logic signed [31:0] wv_mem [MAX_ROWS];

  amgs_state_t state_r, state_nxt;
  logic [LEN_W-1:0] vl_r, n_len;
  logic [COL_W-1:0] c_r, c_nxt, j_r, j_nxt;
  logic [LEN_W-1:0] iss_r, iss_nxt;
  logic v1_r, v1_nxt, v2_r, v2_nxt;
  logic [ROW_W-1:0] idx1_r, idx1_nxt, idx2_r, idx2_nxt;
  logic signed [63:0] p_r, p_nxt;
  logic signed [31:0] w2_r, w2_nxt, h_r, h_nxt;
  logic [63:0] acc_r, acc_nxt, rem_r, rem_nxt, root_r, root_nxt, bit_r, bit_nxt;
  logic [5:0] k_r, k_nxt;
  logic [31:0] norm_r, norm_nxt, drem_r, drem_nxt;
  logic sign_r, sign_nxt;
  logic [47:0] dv_r, dv_nxt;
  logic out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [COL_W-1:0] out_idx_r, out_idx_nxt;
  logic [31:0] out_val_r, out_val_nxt;
  logic [1:0] out_st_r, out_st_nxt;

  logic wv_we, bs_we;
  logic [ROW_W-1:0] wv_wa, wv_ra;
  logic [ADDR_W-1:0] bs_wa, bs_ra;
  logic signed [31:0] wv_wd, bs_wd, wv_rd_r, bs_rd_r;

  logic out_free, acc_in, issuing, pipe_done;
  logic [COL_W-1:0] in_col;
  logic [ROW_W-1:0] in_row;
  logic signed [31:0] in_val;
  logic signed [31:0] op_a, op_b;
  logic signed [64:0] s65;
  logic [64:0] u65, sq_sum;
  logic signed [63:0] term, diff;
  logic [63:0] root_new;
  logic [32:0] mag, drem2;
  logic [47:0] q;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  assign in_col  = in_tdata[4:0];
  assign in_row  = in_tdata[12:5];
  assign in_val  = in_tdata[44:13];
  assign n_len   = (vl_r > LEN_W'(MAX_ROWS)) ? LEN_W'(MAX_ROWS) : vl_r;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign acc_in    = in_tvalid && in_tready;
  assign issuing   = (state_r == S_DOT || state_r == S_UPD || state_r == S_NORM)
                     && (iss_r < n_len);
  assign pipe_done = (iss_r == n_len) && !v1_r && !v2_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_val_r, out_idx_r};
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (wv_we) wv_mem[wv_wa] <= wv_wd;
    wv_rd_r <= wv_mem[wv_ra];
  end

  always_ff @(posedge clk) begin
    if (bs_we) bs_mem[bs_wa] <= bs_wd;
    bs_rd_r <= bs_mem[bs_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vl_r        <= LEN_W'(MAX_ROWS);
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vl_r        <= cfg_wr_en ? cfg_wr_data : vl_r;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r <= c_nxt;       j_r <= j_nxt;       iss_r <= iss_nxt;
    idx1_r <= idx1_nxt; idx2_r <= idx2_nxt; p_r <= p_nxt;
    w2_r <= w2_nxt;     h_r <= h_nxt;       acc_r <= acc_nxt;
    rem_r <= rem_nxt;   root_r <= root_nxt; bit_r <= bit_nxt;
    k_r <= k_nxt;       norm_r <= norm_nxt; drem_r <= drem_nxt;
    sign_r <= sign_nxt; dv_r <= dv_nxt;
    out_idx_r <= out_idx_nxt; out_val_r <= out_val_nxt;
    out_st_r <= out_st_nxt;   out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    c_nxt = c_r;   j_nxt = j_r;   iss_nxt = iss_r;
    idx1_nxt = iss_r[ROW_W-1:0];  idx2_nxt = idx1_r;
    v1_nxt = issuing;  v2_nxt = v1_r;
    w2_nxt = wv_rd_r;  h_nxt = h_r;  acc_nxt = acc_r;
    rem_nxt = rem_r;   root_nxt = root_r;  bit_nxt = bit_r;  k_nxt = k_r;
    norm_nxt = norm_r; drem_nxt = drem_r;  sign_nxt = sign_r; dv_nxt = dv_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_idx_nxt = out_idx_r; out_val_nxt = out_val_r;
    out_st_nxt = out_st_r;   out_last_nxt = out_last_r;
    wv_we = 1'b0; wv_wa = in_row; wv_wd = in_val;
    bs_we = 1'b0; bs_wa = {in_col, in_row}; bs_wd = in_val;
    wv_ra = iss_r[ROW_W-1:0];
    bs_ra = {j_r, iss_r[ROW_W-1:0]};
    root_new = '0;

    // stage 1: product
    unique case (state_r)
      S_UPD:   begin op_a = h_r;     op_b = bs_rd_r; end
      S_NORM:  begin op_a = wv_rd_r; op_b = wv_rd_r; end
      default: begin op_a = bs_rd_r; op_b = wv_rd_r; end
    endcase
    p_nxt = op_a * op_b;

    // stage 2: accumulate or write back
    s65  = {p_r[63], p_r} + {acc_r[63], acc_r};
    u65  = {1'b0, p_r} + {1'b0, acc_r};
    term = p_r >>> 16;
    diff = {{32{w2_r[31]}}, w2_r} - term;
    if (issuing) iss_nxt = iss_r + 1'b1;
    if (v2_r) begin
      if (state_r == S_DOT) begin
        if (s65[64] != s65[63])
          acc_nxt = s65[64] ? 64'h8000000000000000 : 64'h7fffffffffffffff;
        else
          acc_nxt = s65[63:0];
      end else if (state_r == S_NORM) begin
        acc_nxt = u65[64] ? '1 : u65[63:0];
      end else begin
        wv_we = 1'b1;
        wv_wa = idx2_r;
        wv_wd = sat32(diff);
      end
    end

    sq_sum = {1'b0, root_r} + {1'b0, bit_r};
    mag    = wv_rd_r[31] ? 33'(-{wv_rd_r[31], wv_rd_r}) : {1'b0, wv_rd_r};
    drem2  = {drem_r, dv_r[47]};
    q      = dv_r;

    unique case (state_r)
      S_IDLE: begin
        bs_ra = {in_col, in_row};
        if (acc_in) begin
          unique case (amgs_mode_t'(in_tuser))
            MODE_LOAD: begin
              wv_we = 1'b1;
              if (in_tlast) begin
                c_nxt = in_col;
                if (in_col == COL_W'(MAX_COLUMNS - 1)) begin
                  out_valid_nxt = 1'b1;
                  out_idx_nxt = in_col; out_val_nxt = '0;
                  out_st_nxt = ST_RANGE; out_last_nxt = 1'b1;
                end else begin
                  j_nxt = '0; iss_nxt = '0; acc_nxt = '0;
                  state_nxt = S_DOT;
                end
              end
            end
            MODE_WRITE: bs_we = 1'b1;
            MODE_READ:  state_nxt = S_READ;
            default: ;
          endcase
        end
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        out_idx_nxt = '0; out_val_nxt = bs_rd_r;
        out_st_nxt = ST_OK; out_last_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_DOT: begin
        if (pipe_done) begin
          h_nxt = sat32($signed(acc_r) >>> 16);
          state_nxt = S_HOUT;
        end
      end
      S_HOUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt = j_r; out_val_nxt = h_r;
          out_st_nxt = ST_OK; out_last_nxt = 1'b0;
          iss_nxt = '0;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (pipe_done) begin
          iss_nxt = '0; acc_nxt = '0;
          if (j_r == c_r) begin
            state_nxt = S_NORM;
          end else begin
            j_nxt = j_r + 1'b1;
            state_nxt = S_DOT;
          end
        end
      end
      S_NORM: begin
        if (pipe_done) begin
          rem_nxt = acc_r; root_nxt = '0; bit_nxt = 64'h4000000000000000;
          k_nxt = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if ({1'b0, rem_r} >= sq_sum) begin
          rem_nxt  = rem_r - sq_sum[63:0];
          root_new = (root_r >> 1) + bit_r;
        end else begin
          root_new = root_r >> 1;
        end
        root_nxt = root_new;
        bit_nxt  = bit_r >> 2;
        k_nxt    = k_r + 1'b1;
        if (k_r == 6'd31) begin
          norm_nxt = (root_new > 64'h7fffffff) ? 32'h7fffffff : root_new[31:0];
          iss_nxt  = '0;
          state_nxt = (root_new == '0) ? S_NOUT : S_DRD;
        end
      end
      S_DRD: begin
        state_nxt = (iss_r == n_len) ? S_NOUT : S_DLD;
      end
      S_DLD: begin
        sign_nxt = wv_rd_r[31];
        dv_nxt   = {mag[31:0], 16'h0000};
        drem_nxt = '0;
        k_nxt    = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (drem2 >= {1'b0, norm_r}) begin
          drem_nxt = 32'(drem2 - {1'b0, norm_r});
          dv_nxt   = {dv_r[46:0], 1'b1};
        end else begin
          drem_nxt = drem2[31:0];
          dv_nxt   = {dv_r[46:0], 1'b0};
        end
        k_nxt = k_r + 1'b1;
        if (k_r == 6'd47) state_nxt = S_DWR;
      end
      S_DWR: begin
        bs_we = 1'b1;
        bs_wa = {c_r + 1'b1, iss_r[ROW_W-1:0]};
        if (!sign_r) bs_wd = (q > 48'h7fffffff) ? 32'h7fffffff : q[31:0];
        else         bs_wd = (q > 48'h80000000) ? 32'h80000000 : 32'(-q[31:0]);
        iss_nxt = iss_r + 1'b1;
        state_nxt = S_DRD;
      end
      S_NOUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt = c_r + 1'b1;
          out_val_nxt = norm_r;
          out_st_nxt  = (norm_r == '0) ? ST_BREAKDOWN : ST_OK;
          out_last_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// Gram-Schmidt Arnoldi step unit testbench
// Streams loads, basis writes, reads and step starts into the unit, predicts
// every coefficient, norm and read result in fixed point, and compares each
// output beat field by field under random idling and a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import amgs_pkg::*;

  typedef struct {
    logic [1:0]  mode;
    logic [4:0]  col;
    logic [7:0]  row;
    logic [31:0] value;
    logic        last;
  } item_t;

  typedef struct {
    logic [4:0]   idx;
    logic [31:0]  value;
    amgs_status_t status;
    logic         last;
  } result_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_wr_en = 0;
  logic [8:0]  cfg_wr_data = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [47:0] in_tdata = 0;
  logic [1:0]  in_tuser = 0;
  logic        in_tlast = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  item_t   beat_q[$];
  result_t result_q[$];
  int      errors = 0;
  int      results_seen = 0;
  bit      idle_on = 1;
  int      hold_cnt = 0;
  bit      hold_done = 0;

  logic signed [31:0] basis_mem [0:MAX_ROWS*MAX_COLUMNS-1];
  logic signed [31:0] work_mem [0:MAX_ROWS-1];
  bit                 basis_ok [0:MAX_ROWS*MAX_COLUMNS-1];
  bit                 work_ok [0:MAX_ROWS-1];
  int                 step_len = 256;

  arnoldi_mgs_orthogonalize_unit uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -64'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint sat_add(longint a, longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63])
      return a[63] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
    return s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned rem, root, bitv;
    rem = x;
    root = 0;
    bitv = 64'h4000000000000000;
    for (int k = 0; k < 32; k++) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic void push_result(int idx, longint v, amgs_status_t st, bit l);
    result_t r;
    r.idx = idx[4:0];
    r.value = v[31:0];
    r.status = st;
    r.last = l;
    result_q.push_back(r);
  endfunction

  function automatic void run_orthogonalize(int c);
    int n;
    longint acc, h, term, w;
    longint unsigned sumsq, sq, mag, q, root;
    longint norm;
    n = (step_len < MAX_ROWS) ? step_len : MAX_ROWS;
    if (c + 1 >= MAX_COLUMNS) begin
      push_result(c, 0, ST_RANGE, 1);
      return;
    end
    for (int j = 0; j <= c; j++) begin
      acc = 0;
      for (int i = 0; i < n; i++)
        acc = sat_add(acc, longint'(basis_mem[j*MAX_ROWS+i]) * longint'(work_mem[i]));
      h = sat32(acc >>> 16);
      for (int i = 0; i < n; i++) begin
        term = (h * longint'(basis_mem[j*MAX_ROWS+i])) >>> 16;
        work_mem[i] = sat32(longint'(work_mem[i]) - term);
      end
      push_result(j, h, ST_OK, 0);
    end
    sumsq = 0;
    for (int i = 0; i < n; i++) begin
      w = work_mem[i];
      sq = w * w;
      sumsq = (sumsq + sq < sumsq) ? 64'hFFFFFFFFFFFFFFFF : sumsq + sq;
    end
    root = int_sqrt(sumsq);
    norm = (root > 64'h7FFFFFFF) ? 64'sh7FFFFFFF : longint'(root);
    if (norm == 0) begin
      push_result(c + 1, 0, ST_BREAKDOWN, 1);
      return;
    end
    for (int i = 0; i < n; i++) begin
      w = work_mem[i];
      mag = (w < 0 ? -w : w) << 16;
      q = mag / longint'(norm);
      basis_mem[(c+1)*MAX_ROWS+i] = sat32(w < 0 ? -longint'(q) : longint'(q));
      basis_ok[(c+1)*MAX_ROWS+i] = 1;
    end
    push_result(c + 1, norm, ST_OK, 1);
  endfunction

  task automatic add_beat(amgs_mode_t mode, int col, int row, logic [31:0] v, bit l);
    item_t it;
    it.mode = mode;
    it.col = col[4:0];
    it.row = row[7:0];
    it.value = v;
    it.last = l;
    beat_q.push_back(it);
    case (mode)
      MODE_LOAD: begin
        work_mem[row] = v;
        work_ok[row] = 1;
        if (l) run_orthogonalize(col);
      end
      MODE_WRITE: begin
        basis_mem[col*MAX_ROWS+row] = v;
        basis_ok[col*MAX_ROWS+row] = 1;
      end
      MODE_READ: push_result(0, basis_mem[col*MAX_ROWS+row], ST_OK, 1);
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
      3: return $urandom_range(0, 32'h7FFFF);
      default: return $urandom();
    endcase
  endfunction

  function automatic int deepest_col();
    int d;
    d = -1;
    for (int j = 0; j < MAX_COLUMNS; j++) begin
      for (int i = 0; i < step_len && i < MAX_ROWS; i++)
        if (!basis_ok[j*MAX_ROWS+i]) return d;
      d = j;
    end
    return d;
  endfunction

  task automatic load_and_start(int c);
    for (int i = 0; i < step_len; i++)
      add_beat(MODE_LOAD, (i == step_len - 1) ? c : $urandom_range(0, 31), i,
               pick_value(), i == step_len - 1);
  endtask

  task automatic read_written();
    int col, row;
    for (int t = 0; t < 40; t++) begin
      col = $urandom_range(0, MAX_COLUMNS - 1);
      row = $urandom_range(0, step_len > 16 ? MAX_ROWS - 1 : step_len - 1);
      if (basis_ok[col*MAX_ROWS+row]) begin
        add_beat(MODE_READ, col, row, $urandom(), $urandom_range(0, 1));
        return;
      end
    end
  endtask

  task automatic random_traffic(int budget, bit steps_on);
    int start, d, c, cnt;
    start = beat_q.size();
    while (beat_q.size() - start < budget) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: if (steps_on) begin
          d = deepest_col();
          if (d < 0 || (d < 30 && $urandom_range(0, 3) == 0)) begin
            for (int i = 0; i < step_len; i++)
              add_beat(MODE_WRITE, d + 1, i, pick_value(), $urandom_range(0, 1));
            d = d + 1;
          end
          if ($urandom_range(0, 7) == 0) c = 31;
          else c = $urandom_range(0, d > 30 ? 30 : d);
          load_and_start(c);
        end
        6, 7: read_written();
        8: begin
          add_beat(MODE_NOP, $urandom_range(0, 31), $urandom_range(0, 255),
                   $urandom(), $urandom_range(0, 1));
          add_beat(MODE_LOAD, $urandom_range(0, 31), $urandom_range(0, 255),
                   $urandom(), 0);
          add_beat(MODE_WRITE, $urandom_range(0, 31), $urandom_range(0, 255),
                   $urandom(), $urandom_range(0, 1));
        end
        default: begin
          cnt = $urandom_range(1, step_len > 8 ? 8 : step_len);
          for (int i = 0; i < cnt; i++)
            add_beat(MODE_LOAD, $urandom_range(0, 31), i, pick_value(), 0);
        end
      endcase
    end
  endtask

  task automatic drain_and_config(int len);
    while (beat_q.size() != 0 || in_tvalid || result_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= len[8:0];
    step_len = len;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  always @(posedge clk) begin : beat_driver
    int gap;
    if (!rst_n) begin
      in_tvalid <= 0;
      gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        void'(beat_q.pop_front());
        if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 17);
      end
      if (!(in_tvalid && !in_tready)) begin
        if (gap > 0) begin
          gap--;
          in_tvalid <= 0;
        end else if (beat_q.size() > 0) begin
          in_tvalid <= 1;
          in_tdata <= {3'b0, beat_q[0].value, beat_q[0].row, beat_q[0].col};
          in_tuser <= beat_q[0].mode;
          in_tlast <= beat_q[0].last;
        end else begin
          in_tvalid <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!hold_done && results_seen >= 10) begin
      hold_cnt <= 600;
      hold_done <= 1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk) begin : result_monitor
    int stall;
    result_t r;
    if (!rst_n) begin
      out_tready <= 0;
      stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result beat");
        end else begin
          r = result_q.pop_front();
          if (out_tdata[4:0] !== r.idx)
            report_mismatch($sformatf("coeff_index %0d, want %0d", out_tdata[4:0], r.idx));
          if (out_tdata[36:5] !== r.value)
            report_mismatch($sformatf("value %h, want %h", out_tdata[36:5], r.value));
          if (out_tuser !== r.status)
            report_mismatch($sformatf("status %0d, want %0d", out_tuser, r.status));
          if (out_tlast !== r.last)
            report_mismatch($sformatf("last %b, want %b", out_tlast, r.last));
        end
      end
      if (hold_cnt > 0) begin
        out_tready <= 0;
      end else if (stall > 0) begin
        stall--;
        out_tready <= 0;
      end else begin
        out_tready <= 1;
        if (idle_on && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 17);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    for (int i = 0; i < MAX_ROWS*MAX_COLUMNS; i++) begin
      basis_mem[i] = 0;
      basis_ok[i] = 0;
    end
    for (int i = 0; i < MAX_ROWS; i++) begin
      work_mem[i] = 0;
      work_ok[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    drain_and_config(1);
    add_beat(MODE_WRITE, 0, 0, 32'h00010000, 0);
    add_beat(MODE_LOAD, 0, 0, 32'h7FFFFFFF, 1);
    add_beat(MODE_LOAD, 0, 0, 32'h00000000, 1);
    add_beat(MODE_LOAD, 0, 0, 32'h80000000, 1);
    for (int j = 1; j <= 30; j++)
      add_beat(MODE_WRITE, j, 0, (j % 3 == 0) ? 32'h80000000 :
               (j % 3 == 1) ? 32'h7FFFFFFF : 32'hFFFFFFFF, j % 2);
    add_beat(MODE_LOAD, 0, 0, 32'h00030000, 1);
    add_beat(MODE_LOAD, 30, 0, 32'h7FFFFFFF, 1);
    add_beat(MODE_LOAD, 31, 0, 32'h12345678, 1);
    add_beat(MODE_READ, 0, 0, 32'hFFFFFFFF, 1);
    add_beat(MODE_READ, 30, 0, 0, 0);
    add_beat(MODE_NOP, 31, 255, 32'hFFFFFFFF, 1);
    add_beat(MODE_READ, 15, 0, 0, 0);

    drain_and_config(4);
    random_traffic(60, 1);
    drain_and_config(255);
    random_traffic(25, 0);
    drain_and_config(7);
    random_traffic(40, 1);
    drain_and_config(3);
    idle_on = 0;
    random_traffic(25, 1);
    drain_and_config(256);
    add_beat(MODE_WRITE, 1, 255, pick_value(), 0);
    add_beat(MODE_READ, 1, 255, 0, 1);

    while (beat_q.size() != 0 || in_tvalid || result_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> filelist.f
hdl/amgs_pkg.sv
hdl/arnoldi_mgs_orthogonalize_unit.sv
verif/testbench.sv
